// ===== rtl/tsc_pkg.sv =====
// shared types, constants and the arctangent table for the tilt slope classifier
`default_nettype none

package tsc_pkg;

    // parameter defaults
    localparam int ANGLE_ITERATIONS_DEF     = 16;
    localparam int FILTER_FRACTION_BITS_DEF = 8;

    // slope classes
    localparam logic [1:0] SLOPE_LEVEL = 2'd0;
    localparam logic [1:0] SLOPE_UP    = 2'd1;
    localparam logic [1:0] SLOPE_DOWN  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_ENTER   = 2'd1;
    localparam logic [1:0] CFG_HYST    = 2'd2;
    localparam logic [1:0] CFG_FWD_Y   = 2'd3;

    // register reset values
    localparam logic [16:0] GAIN_RST  = 17'd13107;
    localparam logic [16:0] GAIN_ONE  = 17'd65536;
    localparam logic [13:0] ENTER_RST = 14'd500;
    localparam logic [13:0] HYST_RST  = 14'd200;

    // pitch limit in centidegrees
    localparam logic signed [15:0] PITCH_LIM = 16'sd9000;

    // multiply slots of the sequencer: three filters, then two squares
    localparam logic [2:0] SLOT_FX   = 3'd0;
    localparam logic [2:0] SLOT_FY   = 3'd1;
    localparam logic [2:0] SLOT_FZ   = 3'd2;
    localparam logic [2:0] SLOT_SQA  = 3'd3;
    localparam logic [2:0] SLOT_SQB  = 3'd4;

    // main sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CORD_GO,
        ST_CORD_WAIT,
        ST_OUT
    } t_state;

    // angle unit phases
    typedef enum logic [1:0] {
        CP_IDLE,
        CP_NORM,
        CP_ITER,
        CP_ROUND
    } t_cord_phase;

    // atan(2^-i) in centidegrees with 16 fraction bits
    function automatic logic [28:0] atan_q16(input logic [4:0] idx);
        logic [28:0] v;
        case (idx)
            5'd0:    v = 29'd294912000;
            5'd1:    v = 29'd174096719;
            5'd2:    v = 29'd91987925;
            5'd3:    v = 29'd46694507;
            5'd4:    v = 29'd23437865;
            5'd5:    v = 29'd11730358;
            5'd6:    v = 29'd5866610;
            5'd7:    v = 29'd2933484;
            5'd8:    v = 29'd1466765;
            5'd9:    v = 29'd733385;
            5'd10:   v = 29'd366693;
            5'd11:   v = 29'd183346;
            5'd12:   v = 29'd91673;
            5'd13:   v = 29'd45837;
            5'd14:   v = 29'd22918;
            5'd15:   v = 29'd11459;
            5'd16:   v = 29'd5730;
            5'd17:   v = 29'd2865;
            5'd18:   v = 29'd1432;
            5'd19:   v = 29'd716;
            5'd20:   v = 29'd358;
            5'd21:   v = 29'd179;
            5'd22:   v = 29'd90;
            5'd23:   v = 29'd45;
            default: v = 29'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tsc_sqrt.sv =====
// iterative floor square root, two radicand bits per cycle
`default_nettype none

module tsc_sqrt
    import tsc_pkg::*;
#(
    parameter int RW = 25
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [2*RW-1:0]   i_radicand,
    output logic                   o_done,
    output logic [RW-1:0]          o_root
);
    localparam int SW   = 2 * RW;
    localparam int CNTW = $clog2(RW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [SW-1:0]   r_rad;
    logic [RW+2:0]   r_rem;
    logic [RW-1:0]   r_root;

    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            ge;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem[RW:0], r_rad[SW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SW-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[RW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/tsc_cordic.sv =====
// vectoring cordic: normalize by single shifts, then one rotation per cycle
`default_nettype none

module tsc_cordic
    import tsc_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF,
    parameter int YW = 26,
    parameter int XW = 25
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [YW-1:0] i_y,
    input  wire logic [XW-1:0]        i_x,
    output logic                      o_done,
    output logic signed [14:0]        o_pitch
);
    localparam int CW = (YW + 2 > 35) ? YW + 2 : 35;

    t_cord_phase r_phase;
    t_cord_phase n_phase;

    logic                 r_done;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic [CW-1:0]        r_m;
    logic signed [31:0]   r_z;
    logic [4:0]           r_iter;
    logic signed [14:0]   r_pitch;

    logic                 start_ok;
    logic                 y_zero;
    logic                 x_zero;
    logic [YW-1:0]        y_abs;
    logic [CW-1:0]        y_abs_ext;
    logic [CW-1:0]        x_ext;
    logic                 m_high;
    logic                 m_low;
    logic                 y_pos;
    logic                 last_iter;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [31:0]   atan_v;
    logic signed [31:0]   z_rnd;
    logic signed [15:0]   z_q;

    // operand checks and per-step values
    always_comb begin
        start_ok  = i_start && (r_phase == CP_IDLE);
        y_zero    = (i_y == '0);
        x_zero    = (i_x == '0);
        y_abs     = i_y[YW-1] ? YW'(-i_y) : i_y;
        y_abs_ext = CW'(y_abs);
        x_ext     = CW'(i_x);
        m_high    = |r_m[CW-1:31];
        m_low     = !r_m[30];
        y_pos     = !r_y[CW-1] && (r_y != '0);
        last_iter = (r_iter == 5'(ANGLE_ITERATIONS - 1));
        xs        = r_x >>> r_iter;
        ys        = r_y >>> r_iter;
        atan_v    = $signed({3'b000, atan_q16(r_iter)});
        z_rnd     = r_z + 32'sd32768;
        z_q       = z_rnd[31:16];
    end

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            CP_IDLE: begin
                if (start_ok && !y_zero && !x_zero) begin
                    n_phase = CP_NORM;
                end
            end
            CP_NORM: begin
                if (!m_high && !m_low) begin
                    n_phase = CP_ITER;
                end
            end
            CP_ITER: begin
                if (last_iter) begin
                    n_phase = CP_ROUND;
                end
            end
            CP_ROUND: n_phase = CP_IDLE;
            default:  n_phase = CP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= CP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (start_ok && (y_zero || x_zero)) || (r_phase == CP_ROUND);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_phase)
            CP_IDLE: begin
                r_x <= $signed(x_ext);
                r_y <= CW'(i_y);
                r_m <= (y_abs_ext > x_ext) ? y_abs_ext : x_ext;
                r_z    <= '0;
                r_iter <= '0;
                // degenerate angles come out exactly
                if (start_ok && y_zero) begin
                    r_pitch <= '0;
                end else if (start_ok && x_zero) begin
                    r_pitch <= i_y[YW-1] ? -15'sd9000 : 15'sd9000;
                end
            end
            CP_NORM: begin
                if (m_high) begin
                    r_x <= r_x >>> 1;
                    r_y <= r_y >>> 1;
                    r_m <= r_m >> 1;
                end else if (m_low) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                    r_m <= r_m << 1;
                end
            end
            CP_ITER: begin
                if (y_pos) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end
                r_iter <= r_iter + 1'b1;
            end
            CP_ROUND: begin
                if (z_q > PITCH_LIM) begin
                    r_pitch <= 15'sd9000;
                end else if (z_q < -PITCH_LIM) begin
                    r_pitch <= -15'sd9000;
                end else begin
                    r_pitch <= z_q[14:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_pitch = r_pitch;

endmodule

`default_nettype wire

// ===== rtl/tilt_slope_classifier.sv =====
// top level: filters, shared multiplier sequencer, root, angle and slope machine
`default_nettype none

// Pitch and slope class from raw 3-axis accelerometer samples. One transaction
// is in flight at a time; the input stalls from acceptance until the result has
// been moved to the output register. The very first sample after reset preloads
// the filters and goes to the output with a pitch of zero, skipping the
// multiplier, root and angle steps. For every later sample the angle unit
// makes 7 to 30 single-bit normalizing shifts before the angle iterations
// with default parameters. When the forward axis or the root is zero the
// angle comes out without iterating. A stalled output holds the sequencer in
// its output state. The work of a sample lies in the five passes through the
// shared multiplier (three filter updates, two squares), the root unit that
// retires two radicand bits a cycle, and the angle unit that does one shift or
// rotation a cycle. The user must write configuration only while no
// transaction is open; the block itself does not enforce this.
module tilt_slope_classifier
    import tsc_pkg::*;
#(
    parameter int ANGLE_ITERATIONS     = ANGLE_ITERATIONS_DEF,
    parameter int FILTER_FRACTION_BITS = FILTER_FRACTION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [16:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_slope,
    output logic signed [14:0]      o_pitch,
    output logic                    o_changed
);
    localparam int F  = FILTER_FRACTION_BITS;
    localparam int FW = 17 + F;
    localparam int OW = 18 + F;
    localparam int PW = 2 * OW;
    localparam int RW = 17 + F;
    localparam int SW = 2 * RW;
    localparam int YW = FW + 1;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [16:0] r_gain;
    logic [13:0] r_enter;
    logic [13:0] r_hyst;
    logic        r_fwd_y;

    // filter and class state
    logic signed [FW-1:0] r_fx;
    logic signed [FW-1:0] r_fy;
    logic signed [FW-1:0] r_fz;
    logic [1:0]           r_class;
    logic                 r_primed;

    // working registers
    logic signed [15:0]   r_sx;
    logic signed [15:0]   r_sy;
    logic signed [15:0]   r_sz;
    logic [2:0]           r_slot;
    logic signed [PW-1:0] r_prod;
    logic [SW-1:0]        r_sumsq;
    logic signed [14:0]   r_pitch;
    logic                 r_first;

    // output register
    logic                 r_out_valid;
    logic [1:0]           r_slope_o;
    logic signed [14:0]   r_pitch_o;
    logic                 r_changed_o;

    logic                 in_acc;
    logic                 out_free;
    logic                 sqrt_start;
    logic                 sqrt_done;
    logic [RW-1:0]        root;
    logic                 cord_start;
    logic                 cord_done;
    logic signed [14:0]   cord_pitch;
    logic signed [YW-1:0] neg_fwd;

    logic [16:0]          gain_eff;
    logic signed [15:0]   cur_s;
    logic signed [FW-1:0] cur_f;
    logic signed [FW-1:0] target;
    logic signed [OW-1:0] op_a;
    logic signed [OW-1:0] op_b;
    logic signed [FW-1:0] sq_src;
    logic signed [PW-1:0] prod_rnd;
    logic signed [PW-1:0] delta;
    logic signed [FW-1:0] f_new;

    logic signed [15:0]   p16;
    logic signed [15:0]   enter16;
    logic signed [15:0]   exit16;
    logic [1:0]           next_class;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RST;
            r_enter <= ENTER_RST;
            r_hyst  <= HYST_RST;
            r_fwd_y <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN:  r_gain  <= i_cfg_data;
                CFG_ENTER: r_enter <= i_cfg_data[13:0];
                CFG_HYST:  r_hyst  <= i_cfg_data[13:0];
                CFG_FWD_Y: r_fwd_y <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // shared multiplier operand selection
    always_comb begin
        gain_eff = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
        case (r_slot)
            SLOT_FX: begin cur_s = r_sx; cur_f = r_fx; end
            SLOT_FY: begin cur_s = r_sy; cur_f = r_fy; end
            default: begin cur_s = r_sz; cur_f = r_fz; end
        endcase
        target = $signed({{(F + 1){cur_s[15]}}, cur_s}) <<< F;
        sq_src = (r_slot == SLOT_SQA) ? (r_fwd_y ? r_fx : r_fy) : r_fz;
        if (r_slot == SLOT_SQA || r_slot == SLOT_SQB) begin
            op_a = OW'(sq_src);
            op_b = OW'(sq_src);
        end else begin
            op_a = $signed({{(OW - 17){1'b0}}, gain_eff});
            op_b = OW'(target) - OW'(cur_f);
        end
        prod_rnd = r_prod + PW'(32768);
        delta    = prod_rnd >>> 16;
        f_new    = cur_f + delta[FW-1:0];
        neg_fwd  = r_fwd_y ? -YW'(r_fy) : -YW'(r_fx);
    end

    // slope machine
    always_comb begin
        p16     = 16'(r_pitch);
        enter16 = $signed({2'b00, r_enter});
        exit16  = $signed({2'b00, r_enter}) - $signed({2'b00, r_hyst});
        next_class = r_class;
        case (r_class)
            SLOPE_LEVEL: begin
                if (p16 > enter16) begin
                    next_class = SLOPE_UP;
                end else if (p16 < -enter16) begin
                    next_class = SLOPE_DOWN;
                end
            end
            SLOPE_UP: begin
                if (p16 < exit16) begin
                    next_class = SLOPE_LEVEL;
                end
            end
            SLOPE_DOWN: begin
                if (p16 > -exit16) begin
                    next_class = SLOPE_LEVEL;
                end
            end
            default: next_class = SLOPE_LEVEL;
        endcase
        if (r_first) begin
            next_class = r_class;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        sqrt_start = 1'b0;
        cord_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = r_primed ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = (r_slot == SLOT_SQB) ? ST_SQRT_GO : ST_MUL;
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                n_state    = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = ST_CORD_GO;
                end
            end
            ST_CORD_GO: begin
                cord_start = 1'b1;
                n_state    = ST_CORD_WAIT;
            end
            ST_CORD_WAIT: begin
                if (cord_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= 1'b0;
            r_class     <= SLOPE_LEVEL;
            r_out_valid <= 1'b0;
            r_slot      <= SLOT_FX;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_primed <= 1'b1;
                r_slot   <= SLOT_FX;
            end
            if (r_state == ST_ACC) begin
                r_slot <= r_slot + 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_class     <= next_class;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sx    <= i_accel_x;
            r_sy    <= i_accel_y;
            r_sz    <= i_accel_z;
            r_first <= !r_primed;
            r_pitch <= '0;
            // first sample preloads the filters
            if (!r_primed) begin
                r_fx <= $signed({{(F + 1){i_accel_x[15]}}, i_accel_x}) <<< F;
                r_fy <= $signed({{(F + 1){i_accel_y[15]}}, i_accel_y}) <<< F;
                r_fz <= $signed({{(F + 1){i_accel_z[15]}}, i_accel_z}) <<< F;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= PW'(op_a) * PW'(op_b);
        end
        if (r_state == ST_ACC) begin
            case (r_slot)
                SLOT_FX:  r_fx    <= f_new;
                SLOT_FY:  r_fy    <= f_new;
                SLOT_FZ:  r_fz    <= f_new;
                SLOT_SQA: r_sumsq <= r_prod[SW-1:0];
                default:  r_sumsq <= r_sumsq + r_prod[SW-1:0];
            endcase
        end
        if (r_state == ST_CORD_WAIT && cord_done) begin
            r_pitch <= cord_pitch;
        end
        if (r_state == ST_OUT && out_free) begin
            r_slope_o   <= next_class;
            r_pitch_o   <= r_pitch;
            r_changed_o <= (next_class != r_class);
        end
    end

    tsc_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sumsq),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    tsc_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS),
        .YW               (YW),
        .XW               (RW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (neg_fwd),
        .i_x     (root),
        .o_done  (cord_done),
        .o_pitch (cord_pitch)
    );

    assign o_out_valid = r_out_valid;
    assign o_slope     = r_slope_o;
    assign o_pitch     = r_pitch_o;
    assign o_changed   = r_changed_o;

`ifndef ASSERT_OFF
    a_primed_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_primed) |=> r_primed)
        else $error("primed flag not set by first sample");

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_class != 2'd3)
        else $error("slope class holds unused code");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result shown outside output state");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch <= 15'sd9000 && o_pitch >= -15'sd9000))
        else $error("pitch out of range");

    a_changed_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free && r_first) |=> !o_changed)
        else $error("first sample flagged as change");
`endif

endmodule

`default_nettype wire
